// File: rtl/shc_pkg.sv
// ----------------------------------------------------------------------------
// shc_pkg
// Shared constants, codes and types of the soil column heat diffusion block.
// ----------------------------------------------------------------------------
package shc_pkg;

  // Column geometry.
  localparam int NZ    = 32;
  localparam int IDX_W = $clog2(NZ);

  // Datapath widths.
  localparam int THETA_W = 32;  // Q16.16 temperature
  localparam int DIFF_W  = 33;  // difference of two temperatures
  localparam int RATE_W  = 16;  // cell_rate, unsigned Q0.16
  localparam int GAIN_W  = 32;  // top_gain, unsigned Q16.16
  localparam int ANCH_W  = 31;  // anchor_theta, unsigned Q15.16
  localparam int PROD_W  = DIFF_W + RATE_W;       // inner face product
  localparam int IFLUX_W = PROD_W - 16;           // inner face flux
  localparam int TPROD_W = GAIN_W + 1 + THETA_W;  // surface face product
  localparam int FLUX_W  = TPROD_W - 16;          // surface face flux
  localparam int SUM_W   = FLUX_W + 2;            // cell update sum
  localparam int CFG_W   = 32;

  // Operation codes.
  localparam logic [1:0] OP_INIT    = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CELL_RATE = 2'd0;
  localparam logic [1:0] CFG_TOP_GAIN  = 2'd1;
  localparam logic [1:0] CFG_ANCHOR    = 2'd2;

  // Reset values.
  localparam logic [RATE_W-1:0]  RESET_RATE   = RATE_W'(1000);
  localparam logic [GAIN_W-1:0]  RESET_GAIN   = GAIN_W'(65536);
  localparam logic [ANCH_W-1:0]  RESET_ANCHOR = ANCH_W'(19660800);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } shc_state_t;

  // Controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic init;
    logic diff_en;
    logic mul_en;
    logic upd_en;
  } shc_cell_ctl_t;

  // Result of a saturating narrowing.
  typedef struct packed {
    logic                       hit;
    logic signed [THETA_W-1:0]  val;
  } shc_clip_t;

  // Saturate a wide sum to the Q16.16 range.
  function automatic shc_clip_t shc_clip(input logic signed [SUM_W-1:0] x);
    shc_clip_t r;
    if (x > SUM_W'(signed'({1'b0, {(THETA_W-1){1'b1}}}))) begin
      r.hit = 1'b1;
      r.val = {1'b0, {(THETA_W-1){1'b1}}};
    end else if (x < SUM_W'(signed'({1'b1, {(THETA_W-1){1'b0}}}))) begin
      r.hit = 1'b1;
      r.val = {1'b1, {(THETA_W-1){1'b0}}};
    end else begin
      r.hit = 1'b0;
      r.val = x[THETA_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/shc_in_if.sv
// ----------------------------------------------------------------------------
// shc_in_if
// Request channel of the soil column block: operation, surface flux, depth.
// ----------------------------------------------------------------------------
interface shc_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         operation;
  logic signed [shc_pkg::THETA_W-1:0] top_flux;
  logic [4:0]                         depth_index;

  modport source (output valid, output operation, output top_flux,
                  output depth_index, input ready);
  modport sink   (input valid, input operation, input top_flux,
                  input depth_index, output ready);
endinterface

// File: rtl/shc_out_if.sv
// ----------------------------------------------------------------------------
// shc_out_if
// Result channel of the soil column block.
// ----------------------------------------------------------------------------
interface shc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [shc_pkg::THETA_W-1:0] surface_theta;
  logic signed [shc_pkg::THETA_W-1:0] cell_theta;
  logic                               saturated;

  modport source (output valid, output surface_theta, output cell_theta,
                  output saturated, input ready);
  modport sink   (input valid, input surface_theta, input cell_theta,
                  input saturated, output ready);
endinterface

// File: rtl/shc_cell.sv
// ----------------------------------------------------------------------------
// shc_cell
// One soil layer: holds its temperature, forms the flux through the face
// below it and applies the explicit update from the two face fluxes.
// ----------------------------------------------------------------------------
module shc_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  shc_pkg::shc_cell_ctl_t              ctl,
  input  logic [shc_pkg::RATE_W-1:0]          cell_rate,
  input  logic signed [shc_pkg::THETA_W-1:0]  anchor,
  input  logic signed [shc_pkg::THETA_W-1:0]  below_theta,
  input  logic signed [shc_pkg::FLUX_W-1:0]   above_flux,
  output logic signed [shc_pkg::THETA_W-1:0]  theta,
  output logic signed [shc_pkg::IFLUX_W-1:0]  below_flux,
  output logic                                hit
);

  logic signed [shc_pkg::THETA_W-1:0] theta_r;
  logic signed [shc_pkg::DIFF_W-1:0]  diff_r;
  logic signed [shc_pkg::IFLUX_W-1:0] flux_r;
  logic signed [shc_pkg::DIFF_W-1:0]  diff_nxt;
  logic signed [shc_pkg::PROD_W-1:0]  prod;
  logic signed [shc_pkg::SUM_W-1:0]   sum;
  shc_pkg::shc_clip_t                 upd;

  // Difference across the face below this cell.
  assign diff_nxt = shc_pkg::DIFF_W'(theta_r) - shc_pkg::DIFF_W'(below_theta);

  // Face flux; dropping the low 16 bits of a signed product rounds toward minus infinity.
  assign prod = $signed({1'b0, cell_rate}) * diff_r;

  // New temperature: old value plus flux in from above minus flux out below.
  assign sum = shc_pkg::SUM_W'(theta_r) + shc_pkg::SUM_W'(above_flux)
             - shc_pkg::SUM_W'(flux_r);
  assign upd = shc_pkg::shc_clip(sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      theta_r <= shc_pkg::THETA_W'(shc_pkg::RESET_ANCHOR);
    end else if (ctl.init) begin
      theta_r <= anchor;
    end else if (ctl.upd_en) begin
      theta_r <= upd.val;
    end
  end

  // Difference and flux stages carry no reset.
  always_ff @(posedge clk) begin
    if (ctl.diff_en) begin
      diff_r <= diff_nxt;
    end
    if (ctl.mul_en) begin
      flux_r <= prod[shc_pkg::PROD_W-1:16];
    end
  end

  assign theta      = theta_r;
  assign below_flux = flux_r;
  assign hit        = upd.hit;

endmodule

// File: rtl/shc_top_face.sv
// ----------------------------------------------------------------------------
// shc_top_face
// Surface face: scales the incoming heat flux by the surface gain.
// ----------------------------------------------------------------------------
module shc_top_face (
  input  logic                                clk,
  input  logic                                mul_en,
  input  logic [shc_pkg::GAIN_W-1:0]          top_gain,
  input  logic signed [shc_pkg::THETA_W-1:0]  top_flux,
  output logic signed [shc_pkg::FLUX_W-1:0]   face_flux
);

  logic signed [shc_pkg::TPROD_W-1:0] prod;
  logic signed [shc_pkg::FLUX_W-1:0]  flux_r;

  // Full product, then floor shift by 16.
  assign prod = $signed({1'b0, top_gain}) * top_flux;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      flux_r <= prod[shc_pkg::TPROD_W-1:16];
    end
  end

  assign face_flux = flux_r;

endmodule

// File: rtl/soil_column_heat_diffusion.sv
// ----------------------------------------------------------------------------
// soil_column_heat_diffusion
// Advance steps through the difference, multiply and update states of the cell
// chain before its result is formed; init, read and unused codes go straight
// to the result. One request is in work at a time: a new request is taken
// only once the previous one has been loaded into the result register. A new
// request is taken while the previous result waits.
// Synchronous reset puts 300 K in every cell and the reset register values.
// ----------------------------------------------------------------------------
module soil_column_heat_diffusion (
  input  logic                             clk,
  input  logic                             rst_n,
  shc_in_if.sink                           in_ch,
  shc_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [shc_pkg::CFG_W-1:0]        cfg_wdata
);

  // Configuration registers.
  logic [shc_pkg::RATE_W-1:0] cell_rate_r;
  logic [shc_pkg::GAIN_W-1:0] top_gain_r;
  logic [shc_pkg::ANCH_W-1:0] anchor_r;

  // Sequencer and request capture.
  shc_pkg::shc_state_t                state_r, state_nxt;
  shc_pkg::shc_cell_ctl_t             ctl;
  logic                               accept;
  logic                               out_load;
  logic [1:0]                         op_r;
  logic [4:0]                         depth_r;
  logic signed [shc_pkg::THETA_W-1:0] flux_in_r;
  logic                               hit_r;

  // Output register.
  logic                               out_valid_r;
  logic signed [shc_pkg::THETA_W-1:0] surf_r;
  logic signed [shc_pkg::THETA_W-1:0] cell_r;
  logic                               sat_r;

  // Chain wiring.
  logic signed [shc_pkg::THETA_W-1:0] anchor_s;
  logic signed [shc_pkg::FLUX_W-1:0]  top_flux_w;
  logic signed [shc_pkg::THETA_W-1:0] theta_w [shc_pkg::NZ];
  logic signed [shc_pkg::IFLUX_W-1:0] flux_w  [shc_pkg::NZ];
  logic [shc_pkg::NZ-1:0]             hit_w;

  // Result forming.
  logic [shc_pkg::IDX_W-1:0]          sel;
  logic signed [shc_pkg::SUM_W-1:0]   surf_sum;
  shc_pkg::shc_clip_t                 surf_clip;

  assign anchor_s = {1'b0, anchor_r};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_rate_r <= shc_pkg::RESET_RATE;
      top_gain_r  <= shc_pkg::RESET_GAIN;
      anchor_r    <= shc_pkg::RESET_ANCHOR;
    end else if (cfg_we) begin
      case (cfg_index)
        shc_pkg::CFG_CELL_RATE: cell_rate_r <= cfg_wdata[shc_pkg::RATE_W-1:0];
        shc_pkg::CFG_TOP_GAIN:  top_gain_r  <= cfg_wdata[shc_pkg::GAIN_W-1:0];
        shc_pkg::CFG_ANCHOR:    anchor_r    <= cfg_wdata[shc_pkg::ANCH_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == shc_pkg::ST_DONE) && (!out_valid_r || out_ch.ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      shc_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (in_ch.operation == shc_pkg::OP_ADVANCE) ? shc_pkg::ST_DIFF
                                                               : shc_pkg::ST_DONE;
        end
      end
      shc_pkg::ST_DIFF: state_nxt = shc_pkg::ST_MUL;
      shc_pkg::ST_MUL:  state_nxt = shc_pkg::ST_UPD;
      shc_pkg::ST_UPD:  state_nxt = shc_pkg::ST_DONE;
      shc_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = shc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = shc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    ctl         = '0;
    case (state_r)
      shc_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        ctl.init    = in_ch.valid && (in_ch.operation == shc_pkg::OP_INIT);
      end
      shc_pkg::ST_DIFF: ctl.diff_en = 1'b1;
      shc_pkg::ST_MUL:  ctl.mul_en  = 1'b1;
      shc_pkg::ST_UPD:  ctl.upd_en  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= shc_pkg::ST_IDLE;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        hit_r <= 1'b0;
      end else if (ctl.upd_en) begin
        hit_r <= |hit_w;
      end
    end
  end

  // Request payload capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_ch.operation;
      depth_r   <= in_ch.depth_index;
      flux_in_r <= in_ch.top_flux;
    end
  end

  // Surface face flux.
  shc_top_face u_top_face (
    .clk       (clk),
    .mul_en    (ctl.mul_en),
    .top_gain  (top_gain_r),
    .top_flux  (flux_in_r),
    .face_flux (top_flux_w)
  );

  // Chain of cells, surface first; the deepest cell sees the anchor below.
  for (genvar i = 0; i < shc_pkg::NZ; i++) begin : g_cell
    logic signed [shc_pkg::THETA_W-1:0] below_t;
    logic signed [shc_pkg::FLUX_W-1:0]  above_f;

    if (i == shc_pkg::NZ - 1) begin : g_last
      assign below_t = anchor_s;
    end else begin : g_mid
      assign below_t = theta_w[i+1];
    end

    if (i == 0) begin : g_first
      assign above_f = top_flux_w;
    end else begin : g_inner
      assign above_f = shc_pkg::FLUX_W'(flux_w[i-1]);
    end

    shc_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .cell_rate   (cell_rate_r),
      .anchor      (anchor_s),
      .below_theta (below_t),
      .above_flux  (above_f),
      .theta       (theta_w[i]),
      .below_flux  (flux_w[i]),
      .hit         (hit_w[i])
    );
  end

  // Read select, clamped to the deepest cell.
  always_comb begin
    if (32'(depth_r) >= shc_pkg::NZ) begin
      sel = shc_pkg::IDX_W'(shc_pkg::NZ - 1);
    end else begin
      sel = shc_pkg::IDX_W'(depth_r);
    end
  end

  // Surface extrapolation: floor((3*top - next) / 2), saturated.
  assign surf_sum  = (shc_pkg::SUM_W'(theta_w[0]) <<< 1) + shc_pkg::SUM_W'(theta_w[0])
                   - shc_pkg::SUM_W'(theta_w[1]);
  assign surf_clip = shc_pkg::shc_clip(surf_sum >>> 1);

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      surf_r <= surf_clip.val;
      cell_r <= (op_r == shc_pkg::OP_READ) ? theta_w[sel] : theta_w[0];
      sat_r  <= hit_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.surface_theta = surf_r;
  assign out_ch.cell_theta    = cell_r;
  assign out_ch.saturated     = sat_r;

endmodule

// File: tb/sv/shc_column_tracker.sv
// ----------------------------------------------------------------------------
// shc_column_tracker
// Watches the request, result and register ports of the soil column block,
// keeps its own copy of the column temperatures and registers, works out the
// result of every accepted request and compares it with what the block sends.
// ----------------------------------------------------------------------------
module shc_column_tracker
  import shc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [1:0]                 in_operation,
  input  logic signed [THETA_W-1:0]  in_top_flux,
  input  logic [4:0]                 in_depth_index,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [THETA_W-1:0]  out_surface_theta,
  input  logic signed [THETA_W-1:0]  out_cell_theta,
  input  logic                       out_saturated,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata,
  output int                         mismatch_count,
  output int                         pending_count,
  output int                         result_count,
  output int                         clipped_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [THETA_W-1:0] surface;
    logic signed [THETA_W-1:0] cell_val;
    logic                      sat;
  } theta_report_t;

  typedef struct packed {
    logic                      hit;
    logic signed [THETA_W-1:0] val;
  } clamp_t;

  // Predicted column and register copies.
  logic signed [THETA_W-1:0] col [NZ];
  logic [RATE_W-1:0]         rate;
  logic [GAIN_W-1:0]         gain;
  logic [ANCH_W-1:0]         anchor;

  // Results still owed by the block, oldest first.
  theta_report_t report_q[$];

  // Narrow a wide value to the Q16.16 range, flagging any clipping.
  function automatic clamp_t clamp_theta(input longint x);
    clamp_t r;
    r.hit = 1'b1;
    if (x > 64'sd2147483647) begin
      r.val = {1'b0, {(THETA_W-1){1'b1}}};
    end else if (x < -64'sd2147483648) begin
      r.val = {1'b1, {(THETA_W-1){1'b0}}};
    end else begin
      r.hit = 1'b0;
      r.val = x[THETA_W-1:0];
    end
    return r;
  endfunction

  // Extrapolated surface: floor((3*top - next) / 2), saturated.
  function automatic logic signed [THETA_W-1:0] surface_of();
    longint t;
    clamp_t c;
    t = 3 * longint'(col[0]) - longint'(col[1]);
    c = clamp_theta(t >>> 1);
    return c.val;
  endfunction

  function automatic void fill_column();
    int i;
    for (i = 0; i < NZ; i++) col[i] = signed'({1'b0, anchor});
  endfunction

  // One explicit time step over all cells from the old values.
  function automatic logic step_column(input logic signed [THETA_W-1:0] flux);
    logic signed [THETA_W-1:0] prev [NZ];
    longint upper_flux;
    longint lower_flux;
    longint below;
    clamp_t c;
    logic   hit;
    int     i;
    prev = col;
    hit = 1'b0;
    for (i = 0; i < NZ; i++) begin
      if (i == 0) begin
        upper_flux = (longint'({32'b0, gain}) * longint'(flux)) >>> 16;
      end else begin
        upper_flux = (longint'({48'b0, rate}) *
                      (longint'(prev[i-1]) - longint'(prev[i]))) >>> 16;
      end
      if (i + 1 < NZ) below = longint'(prev[i+1]);
      else            below = longint'({33'b0, anchor});
      lower_flux = (longint'({48'b0, rate}) * (longint'(prev[i]) - below)) >>> 16;
      c = clamp_theta(longint'(prev[i]) + upper_flux - lower_flux);
      col[i] = c.val;
      hit |= c.hit;
    end
    return hit;
  endfunction

  always @(posedge clk) begin : track
    theta_report_t want;
    theta_report_t got;
    int            idx;
    logic          hit;
    if (!rst_n) begin
      rate   = RESET_RATE;
      gain   = RESET_GAIN;
      anchor = RESET_ANCHOR;
      fill_column();
      report_q.delete();
      mismatch_count = 0;
      result_count   = 0;
      clipped_count  = 0;
    end else begin
      // Register writes are for the user to make only while nothing is in flight; the block does not enforce it.
      if (cfg_we) begin
        case (cfg_index)
          CFG_CELL_RATE: rate   = cfg_wdata[RATE_W-1:0];
          CFG_TOP_GAIN:  gain   = cfg_wdata[GAIN_W-1:0];
          CFG_ANCHOR:    anchor = cfg_wdata[ANCH_W-1:0];
          default: ;
        endcase
      end

      // Compare a delivered result with the oldest prediction.
      if (out_valid && out_ready) begin
        got = '{out_surface_theta, out_cell_theta, out_saturated};
        result_count++;
        if (report_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] result with no request outstanding: surface %h cell %h sat %b",
                     $realtime, got.surface, got.cell_val, got.sat);
        end else begin
          want = report_q.pop_front();
          if (got.sat) clipped_count++;
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display({"[%0t] mismatch: expected surface %h cell %h sat %b, ",
                        "got surface %h cell %h sat %b"},
                       $realtime, want.surface, want.cell_val, want.sat,
                       got.surface, got.cell_val, got.sat);
          end
        end
      end

      // Apply an accepted request to the predicted column.
      if (in_valid && in_ready) begin
        hit = 1'b0;
        case (in_operation)
          OP_INIT:    fill_column();
          OP_ADVANCE: hit = step_column(in_top_flux);
          default: ;
        endcase
        want.surface = surface_of();
        if (in_operation == OP_READ) begin
          idx = (in_depth_index >= NZ) ? NZ - 1 : int'(in_depth_index);
          want.cell_val = col[idx];
        end else begin
          want.cell_val = col[0];
        end
        want.sat = hit;
        report_q.push_back(want);
      end
    end
    pending_count = report_q.size();
  end

endmodule

// File: tb/sv/soil_column_heat_diffusion_tb.sv
// ----------------------------------------------------------------------------
// soil_column_heat_diffusion_tb
// Drives requests and register settings into the soil column block, with
// random gaps and result stalls, and gives the verdict from the tracker's
// mismatch count. A directed opening covers the extremes and special cases;
// random segments under varied settings follow.
// ----------------------------------------------------------------------------
module soil_column_heat_diffusion_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import shc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RESET_CYCLES  = 8;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int PHASES        = 3;
  localparam int SEGMENTS      = 4;
  localparam int ITEMS_PER_SEG = 92;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            rx_ready  = 1'b0;
  logic            cfg_we    = 1'b0;
  logic [1:0]      cfg_index = CFG_CELL_RATE;
  logic [CFG_W-1:0] cfg_wdata = '0;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int stall_cycles       = 0;
  int n_settings         = 0;
  int n_advances         = 0;
  int n_reads            = 0;

  int mismatch_count;
  int pending_count;
  int result_count;
  int clipped_count;

  shc_in_if  in_ch ();
  shc_out_if out_ch ();

  assign out_ch.ready = rx_ready;

  soil_column_heat_diffusion u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  shc_column_tracker u_tracker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_operation      (in_ch.operation),
    .in_top_flux       (in_ch.top_flux),
    .in_depth_index    (in_ch.depth_index),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_surface_theta (out_ch.surface_theta),
    .out_cell_theta    (out_ch.cell_theta),
    .out_saturated     (out_ch.saturated),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count),
    .result_count      (result_count),
    .clipped_count     (clipped_count)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side stalls at random.
  always @(posedge clk) begin
    rx_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog on cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timed out after %0d cycles without a transfer.", stall_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one request, with a random gap first, and return once it is taken.
  task automatic send_request(input logic [1:0] op, input logic signed [THETA_W-1:0] flux,
                              input logic [4:0] depth);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.top_flux    <= flux;
    in_ch.depth_index <= depth;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    if (op == OP_ADVANCE) n_advances++;
    if (op == OP_READ)    n_reads++;
  endtask

  // Drop the request and wait until every predicted result has arrived.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Write all three registers on consecutive cycles; call only when idle.
  task automatic write_settings(input logic [RATE_W-1:0] rate, input logic [GAIN_W-1:0] gain,
                                input logic [ANCH_W-1:0] anchor);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CELL_RATE;
    cfg_wdata <= CFG_W'(rate);
    @(posedge clk);
    cfg_index <= CFG_TOP_GAIN;
    cfg_wdata <= CFG_W'(gain);
    @(posedge clk);
    cfg_index <= CFG_ANCHOR;
    cfg_wdata <= CFG_W'(anchor);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Random settings, with the extremes and an unstable rate now and then.
  task automatic pick_settings();
    logic [RATE_W-1:0] rate;
    logic [GAIN_W-1:0] gain;
    logic [ANCH_W-1:0] anchor;
    case ($urandom_range(7))
      0:       rate = '0;
      1:       rate = RATE_W'(32768);
      2:       rate = RATE_W'($urandom_range(65535, 32769));
      default: rate = RATE_W'($urandom_range(32768));
    endcase
    case ($urandom_range(7))
      0:       gain = '0;
      1:       gain = '1;
      2:       gain = $urandom;
      default: gain = GAIN_W'($urandom_range(32'h0002_0000));
    endcase
    case ($urandom_range(7))
      0:       anchor = '0;
      1:       anchor = '1;
      2:       anchor = ANCH_W'($urandom);
      default: anchor = ANCH_W'($urandom_range(22000000, 17000000));
    endcase
    write_settings(rate, gain, anchor);
  endtask

  // Mostly time steps and reads, some re-initialization and unused codes.
  task automatic issue_random_item();
    logic [1:0]                op;
    logic signed [THETA_W-1:0] flux;
    int                        r;
    r = $urandom_range(99);
    if      (r < 55) op = OP_ADVANCE;
    else if (r < 88) op = OP_READ;
    else if (r < 96) op = OP_INIT;
    else             op = OP_UNUSED;
    r = $urandom_range(99);
    if (r < 50) begin
      flux = $signed($urandom_range(32'h000F_FFFF)) - 32'sd524288;
    end else if (r < 90) begin
      flux = $urandom;
    end else begin
      case ($urandom_range(3))
        0:       flux = 32'sh7FFF_FFFF;
        1:       flux = 32'sh8000_0000;
        2:       flux = '0;
        default: flux = '1;
      endcase
    end
    send_request(op, flux, 5'($urandom_range(31)));
  endtask

  initial begin
    int phase;
    int seg;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_INIT;
    in_ch.top_flux    = '0;
    in_ch.depth_index = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    sender_idle_pct    = 34;
    receiver_stall_pct = 62;

    // Directed: reset column, reads at both ends, unused code, flux extremes.
    send_request(OP_READ,    '0,            5'd0);
    send_request(OP_READ,    '0,            5'd31);
    send_request(OP_UNUSED,  '1,            5'd31);
    send_request(OP_ADVANCE, '0,            5'd0);
    send_request(OP_ADVANCE, 32'sh7FFF_FFFF, 5'd0);
    send_request(OP_ADVANCE, 32'sh8000_0000, 5'd0);
    send_request(OP_READ,    '0,            5'd1);
    send_request(OP_INIT,    '0,            5'd0);
    send_request(OP_READ,    '0,            5'd17);

    // Rate of one half, largest gain and the hottest anchor: cells clip both ways.
    settle();
    write_settings(RATE_W'(32768), '1, '1);
    send_request(OP_INIT,    '0,            5'd0);
    send_request(OP_ADVANCE, 32'sh7FFF_FFFF, 5'd0);
    send_request(OP_READ,    '0,            5'd0);
    send_request(OP_ADVANCE, 32'sh8000_0000, 5'd0);
    send_request(OP_READ,    '0,            5'd1);
    send_request(OP_READ,    '0,            5'd31);
    send_request(OP_ADVANCE, '0,            5'd0);

    // Zero rate and anchor: the surface overflows while later results do
    // not report clipping.
    settle();
    write_settings('0, '1, '0);
    send_request(OP_INIT,    '0,            5'd0);
    send_request(OP_ADVANCE, 32'sh7FFF_FFFF, 5'd0);
    send_request(OP_UNUSED,  '0,            5'd0);
    send_request(OP_READ,    '0,            5'd1);
    send_request(OP_ADVANCE, '1,            5'd0);

    // Random segments under three handshake regimes.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 34;
          receiver_stall_pct = 62;
        end
        1: begin
          sender_idle_pct    = 62;
          receiver_stall_pct = 34;
        end
        default: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
      endcase
      for (seg = 0; seg < SEGMENTS; seg++) begin
        settle();
        pick_settings();
        if ($urandom_range(3) != 0) send_request(OP_INIT, $urandom, 5'($urandom_range(31)));
        repeat (ITEMS_PER_SEG) issue_random_item();
      end
    end

    // Drain and give the verdict.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results across %0d register settings and three handshake regimes.",
             result_count, n_settings + 1);
    $display("Time steps: %0d, cell reads: %0d, results with clipped cells: %0d.",
             n_advances, n_reads, clipped_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches found.", mismatch_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
